### hw/rtl/set_assoc_lru_cache_model_defines.svh
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model_defines.svh
// Assertion macros used by the cache tag model top level.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_MODEL_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SALC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("salc assertion failed");

// Next-cycle implication, disabled in reset.
`define SALC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("salc assertion failed");

`endif

### hw/rtl/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg
// Opcodes, register indexes and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package salc_pkg;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_FETCH = 2'd2;
  localparam logic [1:0] OP_FLUSH = 2'd3;

  localparam logic REG_WAYS_LOG2    = 1'b0;
  localparam logic REG_ENTRIES_LOG2 = 1'b1;

  localparam int ENTRIES_LOG2_MIN = 9;

  typedef struct packed {
    logic load;       // capture item, read set row
    logic commit;     // write back row, post result
    logic clr_step;   // clear one rank row in both stores
    logic flush_rsp;  // post flush result
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic clr_last;
  } status_t;

endpackage

### hw/rtl/set_assoc_lru_cache_model.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model
// Split instruction/data cache tag model with true-LRU replacement.
//
// Each transfer on the input channel is one access: loads and stores look up
// the data store, fetches the instruction store, and a flush invalidates both.
// A lookup reads the set row from the tag and rank memories in the accept
// cycle, then hit detection, victim choice and rank aging run on the
// registered row and the row is written back while the result is posted.
// A flush, and the period after reset, sweeps the rank memories one row a
// cycle over all rows, MAX_ENTRIES divided by the row width (the largest
// power of two up to MAX_WAYS, at most 8), 512 with the default sizes; no
// access is taken meanwhile, but configuration writes are.
// Write configuration only while idle; it takes effect on the next access.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_model #(
  parameter int MAX_ENTRIES = 4096,
  parameter int MAX_WAYS    = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_access_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic        out_counted,
  output logic        out_which_store,
  output logic [2:0]  out_way_used,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_wdata
);
  import salc_pkg::*;
`include "set_assoc_lru_cache_model_defines.svh"

  cmd_t    cmd;
  status_t status;

  // sequencer: owns the handshake and the clearing sweep timing
  salc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // stores, LRU logic and the result register
  salc_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_WAYS    (MAX_WAYS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_opcode         (in_opcode),
    .in_access_address (in_access_address),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_counted       (out_counted),
    .out_which_store   (out_which_store),
    .out_way_used      (out_way_used)
  );

  // one access in flight: a transfer closes the input until it completes
  `SALC_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  // a flush reply carries no hit and way zero
  `SALC_ASSERT_NOW(a_flush_reply, out_valid && !out_which_store && !out_counted,
                   !out_hit && out_way_used == 3'd0)
  // the sequencer never issues a load, write-back or flush reply during a clearing step
  `SALC_ASSERT_NOW(a_cmd_excl, cmd.clr_step, !cmd.commit && !cmd.load && !cmd.flush_rsp)

endmodule

### hw/rtl/salc_ctrl.sv
// ----------------------------------------------------------------------------
// salc_ctrl
// Sequencer: accept, lookup/write-back, rank clearing sweep, flush reply.
// ----------------------------------------------------------------------------
module salc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_opcode,
  output logic             in_ready,
  input  salc_pkg::status_t status,
  output salc_pkg::cmd_t    cmd
);
  import salc_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LOOK  = 2'd1;
  localparam logic [1:0] ST_CLEAR = 2'd2;
  localparam logic [1:0] ST_FDONE = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       pend_r, pend_nxt;

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    in_ready  = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_opcode == OP_FLUSH) begin
            state_nxt = ST_CLEAR;
            pend_nxt  = 1'b1;
          end else begin
            state_nxt = ST_LOOK;
          end
        end
      end
      ST_LOOK: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_nxt = pend_r ? ST_FDONE : ST_IDLE;
        end
      end
      ST_FDONE: begin
        if (status.out_free) begin
          cmd.flush_rsp = 1'b1;
          pend_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

### hw/rtl/salc_dpath.sv
// ----------------------------------------------------------------------------
// salc_dpath
// Tag and rank stores, set lookup, LRU update and result register.
// ----------------------------------------------------------------------------
module salc_dpath #(
  parameter int MAX_ENTRIES = 4096,
  parameter int MAX_WAYS    = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  salc_pkg::cmd_t    cmd,
  output salc_pkg::status_t status,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [3:0]        cfg_wdata,
  input  logic [1:0]        in_opcode,
  input  logic [31:0]       in_access_address,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              out_hit,
  output logic              out_counted,
  output logic              out_which_store,
  output logic [2:0]        out_way_used
);
  import salc_pkg::*;

  localparam int RWL   = (MAX_WAYS >= 8) ? 3 : (MAX_WAYS >= 4) ? 2 : (MAX_WAYS >= 2) ? 1 : 0;
  localparam int RW    = 1 << RWL;
  localparam int OFFW  = (RWL > 0) ? RWL : 1;
  localparam int ELMAX = $clog2(MAX_ENTRIES + 1) - 1;
  localparam int ROWW  = ELMAX - RWL;
  localparam int ROWS  = 1 << ROWW;

  // configuration
  logic [1:0] ways_log2_r;
  logic [3:0] entries_log2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ways_log2_r    <= 2'd0;
      entries_log2_r <= 4'd12;
    end else if (cfg_we) begin
      if (cfg_index == REG_WAYS_LOG2) ways_log2_r <= cfg_wdata[1:0];
      else entries_log2_r <= cfg_wdata;
    end
  end

  logic [1:0]  wl_eff;
  logic [4:0]  el_eff;
  logic [4:0]  set_bits;
  logic [31:0] set_mask;
  logic [31:0] base_in;
  logic [3:0]  ways;

  always_comb begin
    wl_eff = (int'(ways_log2_r) > RWL) ? 2'(RWL) : ways_log2_r;
    if (int'(entries_log2_r) < ENTRIES_LOG2_MIN) el_eff = 5'(ENTRIES_LOG2_MIN);
    else if (int'(entries_log2_r) > ELMAX) el_eff = 5'(ELMAX);
    else el_eff = {1'b0, entries_log2_r};
    set_bits = el_eff - {3'b0, wl_eff};
    set_mask = (32'd1 << set_bits) - 32'd1;
    base_in  = ({2'b00, in_access_address[31:2]} & set_mask) << wl_eff;
    ways     = 4'(4'd1 << wl_eff);
  end

  // captured item
  logic [1:0]      op_r;
  logic [31:0]     addr_r;
  logic [ROWW-1:0] row_r;
  logic [OFFW-1:0] off_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_opcode;
      addr_r <= in_access_address;
      row_r  <= base_in[ELMAX-1 -: ROWW];
      off_r  <= OFFW'(base_in & 32'(RW - 1));
    end
  end

  // stores
  logic [RW-1:0][3:0]  irk_mem [ROWS];
  logic [RW-1:0][3:0]  drk_mem [ROWS];
  logic [RW-1:0][31:0] itg_mem [ROWS];
  logic [RW-1:0][31:0] dtg_mem [ROWS];
  logic [RW-1:0][3:0]  irk_rd_r, drk_rd_r;
  logic [RW-1:0][31:0] itg_rd_r, dtg_rd_r;

  logic [ROWW-1:0]     clr_cnt_r;
  logic [RW-1:0][3:0]  rk_new;
  logic [RW-1:0][31:0] tg_new;
  logic                use_instr;
  logic [ROWW-1:0]     wr_row;
  logic [RW-1:0][3:0]  rk_wdata;

  assign use_instr = (op_r == OP_FETCH);
  assign wr_row    = cmd.clr_step ? clr_cnt_r : row_r;
  assign rk_wdata  = cmd.clr_step ? '0 : rk_new;

  always_ff @(posedge clk) begin
    if (cmd.clr_step || (cmd.commit && use_instr)) irk_mem[wr_row] <= rk_wdata;
    if (cmd.clr_step || (cmd.commit && !use_instr)) drk_mem[wr_row] <= rk_wdata;
    if (cmd.commit && use_instr) itg_mem[row_r] <= tg_new;
    if (cmd.commit && !use_instr) dtg_mem[row_r] <= tg_new;
    if (cmd.load) begin
      irk_rd_r <= irk_mem[base_in[ELMAX-1 -: ROWW]];
      drk_rd_r <= drk_mem[base_in[ELMAX-1 -: ROWW]];
      itg_rd_r <= itg_mem[base_in[ELMAX-1 -: ROWW]];
      dtg_rd_r <= dtg_mem[base_in[ELMAX-1 -: ROWW]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + 1'b1;
  end

  // lookup and LRU aging
  logic            hit;
  logic [OFFW-1:0] sel;
  logic [2:0]      way_sel;

  always_comb begin
    logic [RW-1:0][3:0]  rk;
    logic [RW-1:0][31:0] tg;
    logic [RW-1:0]       in_set;
    logic                found_free;
    logic [3:0]          best;
    logic [3:0]          old;
    rk         = use_instr ? irk_rd_r : drk_rd_r;
    tg         = use_instr ? itg_rd_r : dtg_rd_r;
    hit        = 1'b0;
    sel        = '0;
    found_free = 1'b0;
    best       = 4'd0;
    for (int j = 0; j < RW; j++) begin
      in_set[j] = (j >= int'(off_r)) && (j < int'(off_r) + int'(ways));
    end
    for (int j = 0; j < RW; j++) begin
      if (!hit && in_set[j] && rk[j] != 4'd0 && tg[j] == addr_r) begin
        hit = 1'b1;
        sel = OFFW'(j);
      end
    end
    if (!hit) begin
      for (int j = 0; j < RW; j++) begin
        if (in_set[j] && !found_free) begin
          if (rk[j] == 4'd0) begin
            sel        = OFFW'(j);
            found_free = 1'b1;
          end else if (rk[j] > best) begin
            best = rk[j];
            sel  = OFFW'(j);
          end
        end
      end
    end
    old = hit ? rk[sel] : ways;
    rk_new = rk;
    tg_new = tg;
    for (int j = 0; j < RW; j++) begin
      if (j == int'(sel)) begin
        rk_new[j] = 4'd1;
        tg_new[j] = addr_r;
      end else if (in_set[j] && rk[j] != 4'd0 && rk[j] < old) begin
        rk_new[j] = rk[j] + 4'd1;
      end
    end
    way_sel = 3'(OFFW'(sel - off_r));
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.commit || cmd.flush_rsp) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit         <= hit;
      out_counted     <= (op_r == OP_LOAD) || (op_r == OP_FETCH);
      out_which_store <= !use_instr;
      out_way_used    <= way_sel;
    end else if (cmd.flush_rsp) begin
      out_hit         <= 1'b0;
      out_counted     <= 1'b0;
      out_which_store <= 1'b0;
      out_way_used    <= 3'd0;
    end
  end

  assign status.out_free = !out_valid || out_ready;
  assign status.clr_last = (clr_cnt_r == ROWW'(ROWS - 1));

endmodule
